// ----- sv/assert_macros.svh -----
// assertion macros shared by the warp block rtl
// no dependencies; compiled out when ASSERT_OFF is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define DWT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

`define DWT_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");

`else

`define DWT_ASSERT(lbl, clk, rst_n, prop)

`define DWT_ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

// ----- sv/dwt_pkg.sv -----
// types, constants and coordinate helper for the displacement warp block
// no dependencies
`timescale 1ns / 1ps

package dwt_pkg;

  localparam int unsigned SideBits    = 8;
  localparam int unsigned ImgAddrBits = 2 * SideBits;
  localparam int unsigned TabAddrBits = 8;
  localparam int unsigned PixBits     = 8;
  localparam int unsigned FifoDepth   = 4;
  localparam int unsigned FifoPtrBits = $clog2(FifoDepth);
  localparam int unsigned FifoCntBits = $clog2(FifoDepth + 1);

  typedef enum logic [1:0] {
    OpLoadSource = 2'd0,
    OpLoadX      = 2'd1,
    OpLoadY      = 2'd2,
    OpWarp       = 2'd3
  } op_e;

  typedef struct packed {
    op_e        operation;
    logic [7:0] col;
    logic [7:0] row;
    logic [7:0] data;
    logic [7:0] disp_x_sample;
    logic [7:0] disp_y_sample;
  } in_item_t;

  typedef struct packed {
    logic [7:0] pixel;
    logic [7:0] out_col;
    logic [7:0] out_row;
  } out_item_t;

  typedef struct packed {
    logic [FifoCntBits-1:0] count;
    logic                   full;
  } fifo_status_t;

  // add a signed 8-bit offset to a coordinate, wrapped to the image side
  function automatic logic [SideBits-1:0] wrap_add(input logic [7:0] coord,
                                                   input logic [7:0] off);
    logic [SideBits-1:0] c;
    logic [SideBits-1:0] o;
    c = SideBits'(coord);
    o = SideBits'($signed(off));
    return c + o;
  endfunction

endpackage

// ----- sv/displacement_warp_texture.sv -----
// top level of the displacement-map texture warp block
// depends on dwt_pkg, dwt_ram, dwt_out_fifo and assert_macros.svh
`timescale 1ns / 1ps

// Takes one item per clock while in_ready_o is high: source-pixel loads,
// offset-table loads and warps all enter back to back. A warp reads both
// offset tables at acceptance, the source image in the cycle after, and its
// result enters a four-entry output queue from stage 2.
// Load items give no result. in_ready_o drops only when
// warps in flight plus queued results would fill the queue, i.e. when the
// consumer holds out_ready_i low. The source image and both tables come up
// unknown after reset and must be loaded before a warp reads them; there is
// no clearing pass.

`include "assert_macros.svh"

module displacement_warp_texture (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  dwt_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output dwt_pkg::out_item_t out_item_o
);

  logic in_xfer;

  logic              s1_valid_q, s1_valid_d;
  dwt_pkg::in_item_t s1_item_q;
  logic              s1_warp;
  logic              s1_load_src;

  logic       s2_warp_q, s2_warp_d;
  logic [7:0] s2_col_q;
  logic [7:0] s2_row_q;

  logic [7:0] x_off;
  logic [7:0] y_off;
  logic [7:0] pixel;

  logic [dwt_pkg::SideBits-1:0] warp_col;
  logic [dwt_pkg::SideBits-1:0] warp_row;

  dwt_pkg::out_item_t    push_item;
  dwt_pkg::fifo_status_t fifo_status;

  logic [dwt_pkg::FifoCntBits:0] outstanding;

  // stage 0: table access on transfer
  assign in_xfer = in_valid_i && in_ready_o;

  dwt_ram #(
    .AddrBits (dwt_pkg::TabAddrBits),
    .DataBits (8)
  ) u_x_table (
    .clk_i   (clk_i),
    .we_i    (in_xfer && (in_item_i.operation == dwt_pkg::OpLoadX)),
    .waddr_i (in_item_i.col),
    .wdata_i (in_item_i.data),
    .re_i    (in_xfer && (in_item_i.operation == dwt_pkg::OpWarp)),
    .raddr_i (in_item_i.disp_x_sample),
    .rdata_o (x_off)
  );

  dwt_ram #(
    .AddrBits (dwt_pkg::TabAddrBits),
    .DataBits (8)
  ) u_y_table (
    .clk_i   (clk_i),
    .we_i    (in_xfer && (in_item_i.operation == dwt_pkg::OpLoadY)),
    .waddr_i (in_item_i.col),
    .wdata_i (in_item_i.data),
    .re_i    (in_xfer && (in_item_i.operation == dwt_pkg::OpWarp)),
    .raddr_i (in_item_i.disp_y_sample),
    .rdata_o (y_off)
  );

  assign s1_valid_d = in_xfer;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_item_q <= in_item_i;
    end
  end

  // stage 1: displaced address, image access
  assign s1_warp     = s1_valid_q && (s1_item_q.operation == dwt_pkg::OpWarp);
  assign s1_load_src = s1_valid_q && (s1_item_q.operation == dwt_pkg::OpLoadSource);
  assign warp_col    = dwt_pkg::wrap_add(s1_item_q.col, x_off);
  assign warp_row    = dwt_pkg::wrap_add(s1_item_q.row, y_off);

  dwt_ram #(
    .AddrBits (dwt_pkg::ImgAddrBits),
    .DataBits (dwt_pkg::PixBits)
  ) u_image (
    .clk_i   (clk_i),
    .we_i    (s1_load_src),
    .waddr_i ({dwt_pkg::SideBits'(s1_item_q.row), dwt_pkg::SideBits'(s1_item_q.col)}),
    .wdata_i (s1_item_q.data),
    .re_i    (s1_warp),
    .raddr_i ({warp_row, warp_col}),
    .rdata_o (pixel)
  );

  assign s2_warp_d = s1_warp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_warp_q <= 1'b0;
    end else begin
      s2_warp_q <= s2_warp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_warp) begin
      s2_col_q <= s1_item_q.col;
      s2_row_q <= s1_item_q.row;
    end
  end

  // stage 2: result into the queue
  assign push_item.pixel   = pixel;
  assign push_item.out_col = s2_col_q;
  assign push_item.out_row = s2_row_q;

  dwt_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s2_warp_q),
    .push_item_i (push_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .status_o    (fifo_status)
  );

  // credit check: every warp in flight owns a queue slot
  assign outstanding = (dwt_pkg::FifoCntBits + 1)'(fifo_status.count)
                     + (dwt_pkg::FifoCntBits + 1)'(s1_warp)
                     + (dwt_pkg::FifoCntBits + 1)'(s2_warp_q);
  assign in_ready_o  = (outstanding < (dwt_pkg::FifoCntBits + 1)'(dwt_pkg::FifoDepth));

  `DWT_ASSERT(a_credit_bound, clk_i, rst_ni,
    outstanding <= (dwt_pkg::FifoCntBits + 1)'(dwt_pkg::FifoDepth))
  `DWT_ASSERT_NEVER(a_no_overflow, clk_i, rst_ni,
    s2_warp_q && fifo_status.full && !(out_valid_o && out_ready_i))
  `DWT_ASSERT(a_warp_reaches_s2, clk_i, rst_ni, s1_warp |=> s2_warp_q)
  `DWT_ASSERT(a_warp_enters_s1, clk_i, rst_ni,
    (in_xfer && (in_item_i.operation == dwt_pkg::OpWarp)) |=> s1_warp)

endmodule

// ----- sv/dwt_ram.sv -----
// simple dual-port synchronous ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module dwt_ram #(
  parameter int unsigned AddrBits = 8,
  parameter int unsigned DataBits = 8
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AddrBits-1:0] waddr_i,
  input  logic [DataBits-1:0] wdata_i,
  input  logic                re_i,
  input  logic [AddrBits-1:0] raddr_i,
  output logic [DataBits-1:0] rdata_o
);

  localparam int unsigned Depth = 1 << AddrBits;

  logic [DataBits-1:0] mem [Depth];
  logic [DataBits-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/dwt_out_fifo.sv -----
// small result queue between the warp pipeline and the output channel
// depends on dwt_pkg
`timescale 1ns / 1ps

module dwt_out_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  dwt_pkg::out_item_t     push_item_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output dwt_pkg::out_item_t     out_item_o,
  output dwt_pkg::fifo_status_t  status_o
);

  dwt_pkg::out_item_t mem [dwt_pkg::FifoDepth];

  logic [dwt_pkg::FifoPtrBits-1:0] wr_ptr_q, wr_ptr_d;
  logic [dwt_pkg::FifoPtrBits-1:0] rd_ptr_q, rd_ptr_d;
  logic [dwt_pkg::FifoCntBits-1:0] count_q, count_d;
  logic                            pop;

  assign out_valid_o = (count_q != '0);
  assign pop         = out_valid_o && out_ready_i;
  assign out_item_o  = mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    case ({push_i, pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= push_item_i;
    end
  end

  assign status_o.count = count_q;
  assign status_o.full  = (count_q == dwt_pkg::FifoCntBits'(dwt_pkg::FifoDepth));

endmodule
